// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the packet limiter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that prop holds at every rising edge of clk outside reset.
`define PLM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that cond implies prop in the next cycle.
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error(msg);
`else
`define PLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== rtl/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// Types and constants shared by the packet limiter modules.
// ----------------------------------------------------------------------------
package plm_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W = 32;
	localparam int COUNT_W = 16;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/plm_mem.sv =====
// ----------------------------------------------------------------------------
// plm_mem
// Simple dual-port table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module plm_mem #(
	parameter int DEPTH = plm_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(DEPTH),
	parameter int DW = plm_pkg::KEY_W + plm_pkg::COUNT_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/per_source_packet_limiter_core.sv =====
// ----------------------------------------------------------------------------
// per_source_packet_limiter_core
// Per-source-address packet count limiter with an exact-match table.
// ----------------------------------------------------------------------------
// Usage: each input item is one parsed packet (header flags, ethertype and
// source address) offered on in_valid; the block takes it when in_valid is
// high and in_stall is low. One verdict item (drop) leaves on out_valid and
// is taken when out_stall is low. The limit register is written through
// cfg_valid / cfg_ready; cfg_ready is always high.
// Packets that are decided by their headers alone go from idle straight to
// the done state, which moves their verdict into the output register. IPv4
// packets walk the table one entry per cycle through the single read port
// of the table memory, stopping at the first match or after occupancy
// entries, where occupancy is the number of stored addresses (at most
// CAPACITY). One item is in work at a time; the next item is taken as
// soon as the verdict sits in the output register, even if the receiver
// stalls it.
// Reset empties the table at once through its fill count (no clearing pass)
// and sets the limit to 10. A stalled verdict holds in the output register
// and the block takes no new item until it can move the next verdict there.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_source_packet_limiter_core #(
	parameter int CAPACITY = plm_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        eth_header_complete,
	input  logic [15:0] ether_type,
	input  logic        ip_header_complete,
	input  logic [31:0] source_ip,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        drop,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] packet_limit
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int KW = plm_pkg::KEY_W;
	localparam int CW = plm_pkg::COUNT_W;

	plm_pkg::state_t state_q, state_d;

	logic [KW-1:0] key_q;
	logic [OW-1:0] idx_q, idx_d;
	logic [OW-1:0] occ_q;
	logic          occ_inc;
	logic          verdict_q, verdict_d;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          out_valid_q, drop_q, out_load;
	logic [CW-1:0] limit_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr;
	logic [KW+CW-1:0] mem_wdata, mem_rdata;
	logic [KW-1:0] rd_key;
	logic [CW-1:0] rd_count;
	logic          hit;
	logic          in_acc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != plm_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drop = drop_q;

	assign rd_key = mem_rdata[KW+CW-1:CW];
	assign rd_count = mem_rdata[CW-1:0];
	assign hit = rd_valid_s1 && (rd_key == key_q);

	// Read the next stored entry every cycle of the search while any remain.
	assign mem_re = (state_q == plm_pkg::ST_SEARCH) && (idx_q != occ_q);

	plm_mem #(
		.DEPTH(CAPACITY),
		.AW(AW),
		.DW(KW + CW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		verdict_d = verdict_q;
		occ_inc = 1'b0;
		mem_we = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = {key_q, rd_count + CW'(1)};
		out_load = 1'b0;
		case (state_q)
			plm_pkg::ST_IDLE: begin
				if (in_acc) begin
					idx_d = '0;
					if (!eth_header_complete) begin
						verdict_d = 1'b1;
						state_d = plm_pkg::ST_DONE;
					end else if (ether_type != plm_pkg::ETHERTYPE_IPV4) begin
						verdict_d = 1'b0;
						state_d = plm_pkg::ST_DONE;
					end else if (!ip_header_complete) begin
						verdict_d = 1'b1;
						state_d = plm_pkg::ST_DONE;
					end else begin
						state_d = plm_pkg::ST_SEARCH;
					end
				end
			end
			plm_pkg::ST_SEARCH: begin
				if (hit) begin
					// Known address: drop at or above the limit, otherwise count it.
					if (rd_count >= limit_q) begin
						verdict_d = 1'b1;
					end else begin
						verdict_d = 1'b0;
						mem_we = 1'b1;
					end
					state_d = plm_pkg::ST_DONE;
				end else if (idx_q == occ_q) begin
					// Every stored entry has been compared: a new address.
					verdict_d = 1'b0;
					if (occ_q < OW'(CAPACITY)) begin
						mem_we = 1'b1;
						mem_waddr = idx_q[AW-1:0];
						mem_wdata = {key_q, CW'(1)};
						occ_inc = 1'b1;
					end
					state_d = plm_pkg::ST_DONE;
				end else begin
					idx_d = idx_q + OW'(1);
				end
			end
			plm_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = plm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			limit_q <= plm_pkg::LIMIT_RESET;
		end else begin
			idx_q <= idx_d;
			rd_valid_s1 <= mem_re;
			if (occ_inc) begin
				occ_q <= occ_q + OW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= packet_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		verdict_q <= verdict_d;
		if (in_acc) begin
			key_q <= source_ip;
		end
		if (out_load) begin
			drop_q <= verdict_q;
		end
	end

	`PLM_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OW'(CAPACITY), "occupancy above capacity")
	`PLM_ASSERT(a_idx_bound, clk, arst_n, idx_q <= occ_q, "search index past fill count")
	`PLM_ASSERT(a_we_search, clk, arst_n, !mem_we || state_q == plm_pkg::ST_SEARCH, "table write outside search")
	`PLM_ASSERT_NEXT(a_acc_busy, clk, arst_n, in_acc, state_q != plm_pkg::ST_IDLE, "idle after accept")

endmodule

// ===== verif/per_source_packet_limiter_core_tb.sv =====
// ----------------------------------------------------------------------------
// per_source_packet_limiter_core_tb
// Checks the per-source packet limiter against a cycle-free model of its
// table, with random idling on input and output and limit changes between
// test phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module per_source_packet_limiter_core_tb;

	localparam int TABLE_DEPTH = plm_pkg::CAPACITY_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        eth_header_complete = 1'b0;
	logic [15:0] ether_type = '0;
	logic        ip_header_complete = 1'b0;
	logic [31:0] source_ip = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        drop;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] packet_limit = '0;

	// Model of the table: keys and counts in insertion order.
	logic [31:0] known_src[$];
	logic [15:0] src_count[$];
	logic [15:0] limit_now;

	// Verdicts the block still owes, oldest first.
	bit          verdicts_due[$];
	int          mismatch_count = 0;

	// Idling controls: quiet phases have no gaps at all.
	bit          in_quiet = 1'b0;
	bit          out_quiet = 1'b0;

	// Cycles of output back-pressure still to come.
	int          stall_left = 0;

	// Pool of addresses that random traffic keeps coming back to.
	logic [31:0] addr_pool[$];

	per_source_packet_limiter_core DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.eth_header_complete(eth_header_complete),
		.ether_type         (ether_type),
		.ip_header_complete (ip_header_complete),
		.source_ip          (source_ip),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.drop               (drop),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.packet_limit       (packet_limit)
	);

	always #5 clk = ~clk;

	// Most gaps are short, a few are long.
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Computes the verdict for one packet and updates the table model the
	// same way the block is meant to.
	function automatic bit judge_packet(bit eth_ok, logic [15:0] etype, bit ip_ok,
			logic [31:0] addr);
		if (!eth_ok)
			return 1'b1;
		if (etype != plm_pkg::ETHERTYPE_IPV4)
			return 1'b0;
		if (!ip_ok)
			return 1'b1;
		foreach (known_src[i]) begin
			if (known_src[i] == addr) begin
				if (src_count[i] >= limit_now)
					return 1'b1;
				src_count[i] = src_count[i] + 16'd1;
				return 1'b0;
			end
		end
		// A new address is only remembered while there is room.
		if (known_src.size() < TABLE_DEPTH) begin
			known_src.push_back(addr);
			src_count.push_back(16'd1);
		end
		return 1'b0;
	endfunction

	function automatic bit is_known(logic [31:0] addr);
		foreach (known_src[i])
			if (known_src[i] == addr)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic report_mismatch(string what, bit got, bit want);
		$display("MISMATCH at %0t: %s got %0b expected %0b", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offers one item after a random gap and records its verdict once the
	// block takes it. Valid stays high between back-to-back items.
	task automatic send_packet(bit eth_ok, logic [15:0] etype, bit ip_ok,
			logic [31:0] addr);
		int gap;
		gap = pick_gap(in_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		eth_header_complete <= eth_ok;
		ether_type <= etype;
		ip_header_complete <= ip_ok;
		source_ip <= addr;
		do
			@(posedge clk);
		while (in_stall);
		verdicts_due.push_back(judge_packet(eth_ok, etype, ip_ok, addr));
	endtask

	task automatic send_ipv4(logic [31:0] addr);
		send_packet(1'b1, plm_pkg::ETHERTYPE_IPV4, 1'b1, addr);
	endtask

	// Lets every outstanding verdict drain, then a little more.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes the limit register; only called while the block is idle.
	task automatic write_limit(logic [15:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		packet_limit <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	// One random item: mostly well-formed IPv4 from the pool, the rest noise.
	task automatic send_random_packet();
		logic [31:0] addr;
		logic [15:0] etype;
		int r;
		addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
		r = $urandom_range(0, 99);
		if (r < 80) begin
			send_ipv4(addr);
		end else begin
			etype = ($urandom_range(0, 1) != 0) ? plm_pkg::ETHERTYPE_IPV4 : 16'($urandom);
			if ($urandom_range(0, 3) == 0)
				addr = $urandom;
			send_packet($urandom_range(0, 3) != 0, etype, 1'($urandom_range(0, 1)), addr);
		end
	endtask

	// Output side: random back-pressure, and every taken verdict is checked
	// against the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with nothing owed", drop, 1'b0);
			end else begin
				if (drop !== verdicts_due[0])
					report_mismatch("drop", drop, verdicts_due[0]);
				void'(verdicts_due.pop_front());
			end
		end
		if (out_quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(1'b0);
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Header-only decisions, field extremes and running up to the reset limit.
	task automatic test_directed();
		send_packet(1'b0, plm_pkg::ETHERTYPE_IPV4, 1'b1, 32'h0A00_0001);
		send_packet(1'b0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
		send_packet(1'b1, 16'h0000, 1'b0, 32'h0000_0000);
		send_packet(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_packet(1'b1, 16'h0801, 1'b0, 32'h1234_5678);
		send_packet(1'b1, 16'h86DD, 1'b1, 32'h1234_5678);
		send_packet(1'b1, plm_pkg::ETHERTYPE_IPV4, 1'b0, 32'hC0A8_0001);
		send_ipv4(32'h0000_0000);
		send_ipv4(32'hFFFF_FFFF);
		// The same source twelve times crosses the reset limit of ten.
		repeat (12)
			send_ipv4(32'hC0A8_0001);
		send_ipv4(32'h0000_0000);
		send_packet(1'b1, plm_pkg::ETHERTYPE_IPV4, 1'b0, 32'hC0A8_0001);
	endtask

	// With a zero limit a new source is still let through once.
	task automatic test_zero_limit();
		write_limit(16'd0);
		send_ipv4(32'h5555_AAAA);
		send_ipv4(32'h5555_AAAA);
		send_ipv4(32'hC0A8_0001);
		send_ipv4(32'h0000_0000);
		send_packet(1'b1, 16'h0806, 1'b1, 32'h5555_AAAA);
	endtask

	// The widest limit, then lowering it below counts already reached.
	task automatic test_limit_extremes();
		write_limit(16'hFFFF);
		repeat (4)
			send_ipv4(32'hC0A8_0001);
		send_ipv4(32'hAAAA_5555);
		write_limit(16'd2);
		send_ipv4(32'hAAAA_5555);
		send_ipv4(32'hAAAA_5555);
		send_ipv4(32'hC0A8_0001);
	endtask

	// Random traffic over a small address pool, in phases with different
	// limits and idling.
	task automatic test_random_traffic();
		logic [15:0] limits[6];
		limits = '{16'd1, 16'd3, 16'd0, 16'd7, 16'hFFFF, 16'd5};
		addr_pool.push_back(32'h0000_0000);
		addr_pool.push_back(32'hFFFF_FFFF);
		repeat (30)
			addr_pool.push_back($urandom);
		foreach (limits[p]) begin
			write_limit(limits[p]);
			in_quiet = (p == 2);
			out_quiet = (p == 4);
			repeat (60)
				send_random_packet();
		end
		in_quiet = 1'b0;
		out_quiet = 1'b0;
	endtask

	// Fills the table to capacity; new sources then pass without being kept.
	task automatic test_table_full();
		logic [31:0] addr;
		logic [31:0] outsider;
		write_limit(16'd4);
		while (known_src.size() < TABLE_DEPTH) begin
			addr = $urandom;
			if (!is_known(addr))
				send_ipv4(addr);
		end
		do
			outsider = $urandom;
		while (is_known(outsider));
		// An address that found no room passes every time.
		repeat (6)
			send_ipv4(outsider);
		// The last stored entry still counts up to its limit.
		repeat (5)
			send_ipv4(known_src[TABLE_DEPTH - 1]);
		write_limit(16'd1);
		repeat (40)
			send_random_packet();
		send_ipv4(known_src[0]);
		send_ipv4(outsider);
	endtask

	initial begin
		limit_now = plm_pkg::LIMIT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_limit();
		test_limit_extremes();
		test_random_traffic();
		test_table_full();
		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Filling the whole table walks it once per insertion; this bound is
	// several times the slowest correct run.
	initial begin
		#60_000_000;
		$display("Timeout at %0t with %0d verdicts owed", $time, verdicts_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/plm_pkg.sv
rtl/plm_mem.sv
rtl/per_source_packet_limiter_core.sv
verif/per_source_packet_limiter_core_tb.sv
